/* design/pbo_pkg.sv */
// Shared types, constants and the sine table generator for the PolyBLEP oscillator.
// No dependencies; every other design file except pbo_if.sv imports this package.
`default_nettype none

package pbo_pkg;

    // APB register map
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_WAVE  = 2'd0,
        REG_STEP  = 2'd1,
        REG_PULSE = 2'd2,
        REG_LEVEL = 2'd3
    } reg_idx_t;

    // Waveform codes
    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [1:0] WAVE_SAW      = 2'd2;
    localparam logic [1:0] WAVE_SQUARE   = 2'd3;

    localparam logic [1:0]  RST_WAVE  = WAVE_SINE;
    localparam logic [30:0] RST_STEP  = 31'd0;
    localparam logic [31:0] RST_PULSE = 32'h8000_0000;
    localparam logic [15:0] RST_LEVEL = 16'h8000;

    typedef struct packed {
        logic [1:0]  wave_select;
        logic [30:0] phase_step;
        logic [31:0] pulse_width;
        logic [15:0] output_level;
    } cfg_t;

    // Waveform values carry 16 fraction bits
    localparam int          ACC_W   = 19;
    localparam int          MULB_W  = 18;
    localparam int          PROD_W  = ACC_W + MULB_W;
    localparam int          ONE_Q16 = 65536;
    localparam int          QUOT_BITS = 16;
    localparam int          CNT_W   = $clog2(QUOT_BITS);

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned SERIES_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    // sin(pi/2 * k / 2^tbits) with 16 fraction bits, Q30 Taylor series, capped at 1.0
    function automatic logic [16:0] quarter_sine(input logic [14:0] k, input int unsigned tbits);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] r;
        longint      sum;
        a    = (HALF_PI_Q30 * 64'(k)) >> tbits;
        a2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * a2) >> 30) / 64'(SERIES_DIV[n]);
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (64'(sum) + 64'd8192) >> 14;
        if (r > 64'(ONE_Q16))
            r = 64'(ONE_Q16);
        return r[16:0];
    endfunction

endpackage

`default_nettype wire

/* design/pbo_if.sv */
// Valid/ready stream interfaces for the oscillator's request and sample channels.
// Depends on nothing; used by pbo_core and the top level.
`default_nettype none

interface pbo_req_if ();
    logic valid;
    logic ready;
    logic sample_request;

    modport source (output valid, output sample_request, input ready);
    modport sink (input valid, input sample_request, output ready);
endinterface

interface pbo_smp_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* design/polyblep_wave_oscillator.sv */
// Band-limited oscillator: sine, triangle, saw, square with PolyBLEP edges, APB configured.
// Request beat to sample valid: S_BASE, S_EDGE, then for each edge residual S_DIV (one pass
// of the shared divider), S_SQR and S_ACC, then S_MUL and S_DONE, where the sample is
// registered; square visits S_EDGE once per edge, with or without a residual.
// One request at a time: the next request beat is taken once the sample is registered;
// a request beat with the bit clear is taken in S_IDLE and starts no sample.
// Reset: phase and handshake state clear, registers take their reset values; no clearing pass.
`default_nettype none

module polyblep_wave_oscillator #(
    parameter int PHASE_BITS      = 32,
    parameter int SAMPLE_BITS     = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pbo_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    pbo_req_if.sink                             request,
    pbo_smp_if.source                           sample
);
    import pbo_pkg::*;

    cfg_t                  cfg;
    div_ctl_t              div_ctl;
    div_stat_t             div_stat;
    logic [PHASE_BITS-1:0] div_num;
    logic [PHASE_BITS-1:0] div_den;
    logic [QUOT_BITS-1:0]  div_quot;

    pbo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbo_divider #(
        .PHASE_BITS (PHASE_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    pbo_core #(
        .PHASE_BITS      (PHASE_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .request  (request),
        .sample   (sample),
        .div_ctl  (div_ctl),
        .div_num  (div_num),
        .div_den  (div_den),
        .div_stat (div_stat),
        .div_quot (div_quot)
    );

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |=> div_stat.busy)
        else $error("divider did not go busy after start");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> !div_stat.busy)
        else $error("divider done while still busy");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready && request.sample_request |=> !request.ready)
        else $error("request taken while a sample is in progress");
`endif

endmodule

`default_nettype wire

/* design/pbo_regs.sv */
// APB configuration registers of the oscillator: wave, step, pulse width, level.
// Depends on pbo_pkg.
`default_nettype none

module pbo_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pbo_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    output pbo_pkg::cfg_t                       cfg
);
    import pbo_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_select  <= RST_WAVE;
            cfg_reg.phase_step   <= RST_STEP;
            cfg_reg.pulse_width  <= RST_PULSE;
            cfg_reg.output_level <= RST_LEVEL;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_WAVE:  cfg_reg.wave_select  <= pwdata[1:0];
                REG_STEP:  cfg_reg.phase_step   <= pwdata[30:0];
                REG_PULSE: cfg_reg.pulse_width  <= pwdata;
                REG_LEVEL: cfg_reg.output_level <= pwdata[15:0];
                default:   cfg_reg.wave_select  <= cfg_reg.wave_select;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WAVE:  prdata = {30'd0, cfg_reg.wave_select};
            REG_STEP:  prdata = {1'b0, cfg_reg.phase_step};
            REG_PULSE: prdata = cfg_reg.pulse_width;
            REG_LEVEL: prdata = {16'd0, cfg_reg.output_level};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* design/pbo_divider.sv */
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den) for num < den.
// Depends on pbo_pkg.
`default_nettype none

module pbo_divider #(
    parameter int PHASE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pbo_pkg::div_ctl_t             ctl,
    input  wire logic [PHASE_BITS-1:0]         num,
    input  wire logic [PHASE_BITS-1:0]         den,
    output pbo_pkg::div_stat_t                 stat,
    output logic [pbo_pkg::QUOT_BITS-1:0]      quot
);
    import pbo_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_BITS - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PHASE_BITS:0]   rem_reg;
    logic [PHASE_BITS:0]   rem_next;
    logic [QUOT_BITS-1:0]  quot_reg;
    logic [PHASE_BITS:0]   shifted;
    logic                  fits;

    // remainder stays below den, so the top bit never carries into the shift
    assign shifted  = {rem_reg[PHASE_BITS-1:0], 1'b0};
    assign fits     = shifted >= {1'b0, den};
    assign rem_next = fits ? (shifted - {1'b0, den}) : shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg  <= {1'b0, num};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QUOT_BITS-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

/* design/pbo_core.sv */
// Oscillator sequencer: phase accumulator, sine ROM, edge residuals, level multiply, output.
// Depends on pbo_pkg, pbo_if; drives the shared pbo_divider.
`default_nettype none

module pbo_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SAMPLE_BITS     = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pbo_pkg::cfg_t                 cfg,
    pbo_req_if.sink                            request,
    pbo_smp_if.source                          sample,
    output pbo_pkg::div_ctl_t                  div_ctl,
    output logic [PHASE_BITS-1:0]              div_num,
    output logic [PHASE_BITS-1:0]              div_den,
    input  wire pbo_pkg::div_stat_t            div_stat,
    input  wire logic [pbo_pkg::QUOT_BITS-1:0] div_quot
);
    import pbo_pkg::*;

    localparam int PB           = PHASE_BITS;
    localparam int STB          = SINE_TABLE_BITS;
    localparam int SINE_ENTRIES = (1 << STB) + 1;
    localparam int SH           = 32 - SAMPLE_BITS;

    localparam logic [STB:0]        SINE_N    = (STB + 1)'(1) << STB;
    localparam logic [PROD_W-1:0]   RND_HALF  = PROD_W'(1) << (SH - 1);
    localparam logic [PROD_W-1:0]   SAT_HI    = (PROD_W'(1) << (SAMPLE_BITS - 1)) - 1'b1;
    localparam logic [PROD_W-1:0]   SAT_LO    = PROD_W'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [ACC_W-1:0] ONE_V = ACC_W'(ONE_Q16);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_BASE = 8'b0000_0010,
        S_EDGE = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_SQR  = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [PB-1:0]                  phase_reg;
    logic [PB-1:0]                  t_reg;
    logic                           edge_reg;
    logic                           edge_next;
    logic                           neg_reg;
    logic                           neg_next;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [PROD_W-1:0]       prod_reg;
    logic [16:0]                    rom_q_reg;
    logic                           out_valid_reg;
    logic [SAMPLE_BITS-1:0]         out_data_reg;

    logic [16:0]                    sine_rom [SINE_ENTRIES];
    logic [STB:0]                   rom_k;
    logic [STB-1:0]                 k0;

    logic [PB+30:0]                 step_wide;
    logic [PB+31:0]                 pulse_wide;
    logic [PB-1:0]                  dt;
    logic [PB-1:0]                  pw;
    logic                           accept;
    logic                           out_free;

    logic [15:0]                    frac;
    logic signed [ACC_W-1:0]        saw_v;
    logic signed [ACC_W-1:0]        abs_saw;
    logic signed [ACC_W-1:0]        base_v;
    logic [PB-1:0]                  edge_t;
    logic [PB-1:0]                  dist_up;
    logic                           has_blep;
    logic                           need_div;
    logic                           after_edge;
    logic                           subtract;
    logic                           more_edges;
    logic [16:0]                    w;
    logic [16:0]                    blep_mag;
    logic signed [ACC_W-1:0]        mul_a;
    logic signed [MULB_W-1:0]       mul_b;

    logic [PROD_W-1:0]              mag;
    logic [PROD_W-1:0]              rnd;
    logic [PROD_W-1:0]              neg_rnd;
    logic [SAMPLE_BITS-1:0]         result;

    // quarter-wave ROM, built at elaboration
    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_rom
        assign sine_rom[g] = quarter_sine(15'(g), STB);
    end

    // registers scale from Q0.32 to Q0.PHASE_BITS
    assign step_wide  = {cfg.phase_step, {PB{1'b0}}};
    assign pulse_wide = {cfg.pulse_width, {PB{1'b0}}};
    assign dt         = {1'b0, step_wide[PB+30:32]};
    assign pw         = pulse_wide[PB+31:32];

    assign accept   = request.valid && request.ready;
    assign out_free = !out_valid_reg || sample.ready;

    // mirror the index on odd quadrants
    assign k0    = phase_reg[PB-3 -: STB];
    assign rom_k = phase_reg[PB-2] ? (SINE_N - {1'b0, k0}) : {1'b0, k0};

    always_ff @(posedge clk)
    begin
        rom_q_reg <= sine_rom[rom_k];
    end

    // naive waveforms
    assign frac    = t_reg[PB-1 -: 16];
    assign saw_v   = $signed({2'b00, frac, 1'b0}) - ONE_V;
    assign abs_saw = saw_v[ACC_W-1] ? -saw_v : saw_v;

    always_comb
    begin
        case (cfg.wave_select)
            WAVE_SINE:     base_v = t_reg[PB-1] ? -$signed({2'b00, rom_q_reg})
                                                : $signed({2'b00, rom_q_reg});
            WAVE_TRIANGLE: base_v = (abs_saw <<< 1) - ONE_V;
            WAVE_SAW:      base_v = saw_v;
            WAVE_SQUARE:   base_v = (t_reg < pw) ? ONE_V : -ONE_V;
            default:       base_v = saw_v;
        endcase
    end

    // edge residual setup: distance to the edge behind or ahead of the phase
    assign edge_t     = edge_reg ? (t_reg - pw) : t_reg;
    assign dist_up    = ~edge_t + 1'b1;
    assign has_blep   = (dt != '0) &&
                        ((cfg.wave_select == WAVE_SAW) || (cfg.wave_select == WAVE_SQUARE));
    assign after_edge = edge_t < dt;
    assign need_div   = has_blep && (after_edge || (dist_up < dt));
    assign subtract   = (cfg.wave_select == WAVE_SAW) || edge_reg;
    assign more_edges = (cfg.wave_select == WAVE_SQUARE) && !edge_reg;

    assign div_num     = after_edge ? edge_t : dist_up;
    assign div_den     = dt;
    assign div_ctl.start = state_reg == S_EDGE && need_div;

    assign w        = 17'(ONE_Q16) - {1'b0, div_quot};
    assign blep_mag = prod_reg[32:16];

    // one multiplier: residual square, then level
    always_comb
    begin
        if (state_reg == S_SQR)
        begin
            mul_a = $signed({2'b00, w});
            mul_b = $signed({1'b0, w});
        end
        else
        begin
            mul_a = acc_reg;
            mul_b = $signed({2'b00, cfg.output_level});
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // round half away from zero, then saturate
    assign mag     = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign rnd     = (mag + RND_HALF) >> SH;
    assign neg_rnd = ~rnd + 1'b1;

    always_comb
    begin
        if (prod_reg[PROD_W-1])
            result = (rnd > SAT_LO) ? SAT_LO[SAMPLE_BITS-1:0] : neg_rnd[SAMPLE_BITS-1:0];
        else
            result = (rnd > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0] : rnd[SAMPLE_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && request.sample_request)
                    state_next = S_BASE;
            end
            S_BASE:
            begin
                acc_next   = base_v;
                edge_next  = 1'b0;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                neg_next = subtract ^ after_edge;
                if (need_div)
                    state_next = S_DIV;
                else if (more_edges)
                    edge_next = 1'b1;
                else
                    state_next = S_MUL;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_SQR;
            end
            S_SQR:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = neg_reg ? (acc_reg - $signed({2'b00, blep_mag}))
                                   : (acc_reg + $signed({2'b00, blep_mag}));
                if (more_edges)
                begin
                    edge_next  = 1'b1;
                    state_next = S_EDGE;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // advance the phase once the current one is captured
            if (accept && request.sample_request)
                phase_reg <= phase_reg + dt;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (sample.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        if (accept)
            t_reg <= phase_reg;
        if (state_reg == S_DONE && out_free)
            out_data_reg <= result;
    end

    assign request.ready     = state_reg == S_IDLE;
    assign sample.valid      = out_valid_reg;
    assign sample.sample_out = out_data_reg;

endmodule

`default_nettype wire

/* tb/sv/pbo_sample_checker.sv */
// Sample checker for the PolyBLEP oscillator: tracks register writes and the phase,
// predicts every sample and compares it with the sample channel.
// Depends on pbo_pkg and the stream interfaces in pbo_if.sv.
module pbo_sample_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [pbo_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    pbo_req_if                             req,
    pbo_smp_if                             smp,
    output int                             errors,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pbo_pkg::*;

    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int          LUT_BITS         = 10;
    localparam longint      UNIT             = 65536;

    cfg_t               shadow;
    logic [31:0]        phase;
    logic [16:0]        sine_lut [0:(1 << LUT_BITS)];
    logic signed [15:0] pending_samples [$];
    int                 mismatches;

    function automatic logic [16:0] sine_point(input int unsigned k);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] rounded;
        longint      acc;
        ang    = (QUARTER_TURN_Q30 * 64'(k)) >> LUT_BITS;
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 7; n++)
        begin
            // next odd power over its factorial, from the previous term
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (64'(acc) + 64'd8192) >> 14;
        return (rounded > 64'd65536) ? 17'd65536 : rounded[16:0];
    endfunction

    function automatic longint residual_mag(input logic [63:0] d, input logic [63:0] dt);
        logic [63:0] x;
        logic [63:0] w;
        x = (d << 16) / dt;
        w = 64'd65536 - x;
        return longint'((w * w) >> 16);
    endfunction

    // Negative just after the wrap, positive just before it
    function automatic longint residual_at(input logic [31:0] t, input logic [31:0] dt);
        logic [63:0] gap;
        if (dt == 0)
            return 0;
        if (t < dt)
            return -residual_mag(64'(t), 64'(dt));
        gap = 64'h1_0000_0000 - 64'(t);
        if (gap < 64'(dt))
            return residual_mag(gap, 64'(dt));
        return 0;
    endfunction

    function automatic logic signed [15:0] expected_sample(input logic [31:0] t);
        logic [31:0] dt;
        logic [11:0] lut_idx;
        logic [10:0] k;
        longint      ramp;
        longint      wave;
        longint      prod;
        longint      mag;
        dt   = {1'b0, shadow.phase_step};
        ramp = 2 * longint'(t[31:16]) - UNIT;
        case (shadow.wave_select)
            WAVE_SINE:
            begin
                lut_idx = t[31:20];
                k       = {1'b0, lut_idx[9:0]};
                // mirror the odd quadrants, negate the second half
                if (lut_idx[10])
                    k = 11'd1024 - k;
                wave = longint'(sine_lut[k]);
                if (lut_idx[11])
                    wave = -wave;
            end
            WAVE_TRIANGLE:
                wave = 2 * ((ramp < 0) ? -ramp : ramp) - UNIT;
            WAVE_SAW:
                wave = ramp - residual_at(t, dt);
            default:
            begin
                wave = (t < shadow.pulse_width) ? UNIT : -UNIT;
                wave = wave + residual_at(t, dt);
                wave = wave - residual_at(t - shadow.pulse_width, dt);
            end
        endcase
        prod = wave * longint'(shadow.output_level);
        mag  = (prod < 0) ? -prod : prod;
        mag  = (mag + 32768) >>> 16;
        if (prod < 0)
            mag = -mag;
        if (mag > 32767)
            mag = 32767;
        else if (mag < -32768)
            mag = -32768;
        return mag[15:0];
    endfunction

    initial
    begin
        for (int k = 0; k <= (1 << LUT_BITS); k++)
            sine_lut[k] = sine_point(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] want;
        if (!rst_n)
        begin
            shadow.wave_select  = RST_WAVE;
            shadow.phase_step   = RST_STEP;
            shadow.pulse_width  = RST_PULSE;
            shadow.output_level = RST_LEVEL;
            phase               = '0;
            mismatches          = 0;
            pending_samples.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_WAVE:  shadow.wave_select  = pwdata[1:0];
                    REG_STEP:  shadow.phase_step   = pwdata[30:0];
                    REG_PULSE: shadow.pulse_width  = pwdata;
                    REG_LEVEL: shadow.output_level = pwdata[15:0];
                    default: ;
                endcase
            end
            if (smp.valid && smp.ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    mismatches++;
                    $error("sample_out: no sample expected, got %0d", smp.sample_out);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (smp.sample_out !== want)
                    begin
                        mismatches++;
                        $error("sample_out: expected %0d, got %0d", want, smp.sample_out);
                    end
                end
            end
            // predict from the phase before the step, then advance
            if (req.valid && req.ready && req.sample_request)
            begin
                pending_samples.push_back(expected_sample(phase));
                phase = phase + {1'b0, shadow.phase_step};
            end
        end
        errors      <= mismatches;
        outstanding <= pending_samples.size();
    end
endmodule

/* tb/sv/tb_polyblep_wave_oscillator.sv */
// Testbench top for polyblep_wave_oscillator: clock, reset, APB register writes,
// request and sample-channel traffic with random idling; verdict from pbo_sample_checker.
// Depends on pbo_pkg, pbo_if.sv, the oscillator RTL and pbo_sample_checker.sv.
module tb_polyblep_wave_oscillator;
    timeunit 1ns;
    timeprecision 1ps;

    import pbo_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_SETS   = 20;
    localparam int SET_SAMPLES   = 100;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    int                    errors;
    int                    outstanding;
    int                    cycle_count = 0;
    bit                    gaps_on     = 1'b1;
    bit                    hold_sink   = 1'b0;

    pbo_req_if                    req_ch ();
    pbo_smp_if #(.SAMPLE_BITS(16)) smp_ch ();

    polyblep_wave_oscillator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (req_ch),
        .sample  (smp_ch)
    );

    pbo_sample_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req         (req_ch),
        .smp         (smp_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sample sink: random stalls, plus one long hold-off to back up the request side
    initial
    begin
        smp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                smp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                smp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                smp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input logic bit_val);
        req_ch.valid          <= 1'b1;
        req_ch.sample_request <= bit_val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid          <= 1'b0;
            req_ch.sample_request <= 1'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Drain the oscillator, then write all four registers; unused data bits carry noise
    task automatic write_config(input logic [1:0] wave, input logic [30:0] step,
                                input logic [31:0] width, input logic [15:0] level);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(REG_WAVE, {30'($urandom), wave});
        apb_write(REG_STEP, {1'($urandom), step});
        apb_write(REG_PULSE, width);
        apb_write(REG_LEVEL, {16'($urandom), level});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [1:0]  wave;
        logic [30:0] step;
        logic [31:0] width;
        logic [15:0] level;
        logic        bit_val;
        int          sent;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.sample_request = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: sine with zero increment, so the phase holds; a clear bit yields nothing
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);

        // Triangle at quarter-cycle steps: corners and zero crossings
        write_config(WAVE_TRIANGLE, 31'h4000_0000, RST_PULSE, RST_LEVEL);
        repeat (4) send_request(1'b1);

        // Sine across the quadrant boundaries
        write_config(WAVE_SINE, 31'h2000_0000, RST_PULSE, RST_LEVEL);
        repeat (5) send_request(1'b1);

        // Saw at the largest increment: residual on nearly every sample
        write_config(WAVE_SAW, 31'h7FFF_FFFF, 32'hFFFF_FFFF, RST_LEVEL);
        repeat (4) send_request(1'b1);

        // Square with zero pulse width and gain above unity
        write_config(WAVE_SQUARE, 31'h1000_0000, 32'h0000_0000, 16'hFFFF);
        repeat (3) send_request(1'b1);

        // Pulse shorter than the increment: both corrections overlap
        write_config(WAVE_SQUARE, 31'h1000_0000, 32'h0800_0000, 16'hFFFF);
        repeat (4) send_request(1'b1);

        // Full-width pulse at zero level
        write_config(WAVE_SQUARE, 31'h0100_0000, 32'hFFFF_FFFF, 16'h0000);
        repeat (2) send_request(1'b1);

        for (int set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            wave = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       step = 31'h0000_0000;
                1:       step = 31'h7FFF_FFFF;
                2:       step = 31'($urandom_range(1, 255));
                3, 4:    step = 31'($urandom & 32'h0FFF_FFFF);
                default: step = 31'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       width = 32'h0000_0000;
                1:       width = 32'hFFFF_FFFF;
                2:       width = 32'($urandom_range(0, 32'h00FF_FFFF));
                default: width = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       level = 16'h0000;
                1:       level = 16'hFFFF;
                2:       level = RST_LEVEL;
                3:       level = 16'($urandom);
                default: level = 16'($urandom_range(0, 32768));
            endcase
            write_config(wave, step, width, level);
            // no idling over the closing sets
            gaps_on = (set_no < RANDOM_SETS - 3) && ($urandom_range(0, 3) != 0);
            if (set_no == 6)
                hold_sink = 1'b1;
            sent = 0;
            while (sent < SET_SAMPLES)
            begin
                bit_val = ($urandom_range(0, 9) != 0);
                send_request(bit_val);
                if (bit_val)
                    sent++;
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
